### sv/dbss_pkg.sv
// Shared types and constants for the double-byte aware substring search.
`default_nettype none
package dbss_pkg;

  localparam int PAT_BYTES = 8;                 // bytes held by the pattern register
  localparam int PAT_W     = 8 * PAT_BYTES;     // pattern register width
  localparam int LEN_W     = 4;                 // pattern length register width
  localparam int SEL_W     = $clog2(PAT_BYTES); // byte select into the pattern
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = PAT_W;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'd1;

  typedef logic [7:0]       byte_t;
  typedef logic [PAT_W-1:0] pattern_t;
  typedef logic [LEN_W-1:0] len_t;

  // Control shared by every cell of the chain.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // What each cell reports about the window after the current shift.
  typedef struct packed {
    logic hit;
    logic start_ok;
  } cell_stat_t;

endpackage
`default_nettype wire

### sv/dbss_if.sv
// Stream interfaces for text bytes in and search results out.
`default_nettype none
interface dbss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink (input valid, input text_byte, input last_byte, output ready);
endinterface

interface dbss_out_if #(
  parameter int POSITION_BITS = 16
);
  logic                     valid;
  logic                     ready;
  logic                     found;
  logic [POSITION_BITS-1:0] start_position;

  modport source (output valid, output found, output start_position, input ready);
  modport sink (input valid, input found, input start_position, output ready);
endinterface
`default_nettype wire

### sv/dbss_cell.sv
// One cell of the window chain: holds a text byte and its start flag.
`default_nettype none
module dbss_cell #(
  parameter int K = 0
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  dbss_pkg::cell_ctrl_t ctrl,
  input  dbss_pkg::pattern_t   pattern,
  input  dbss_pkg::len_t       eff_len,
  input  dbss_pkg::byte_t      byte_in,
  input  wire                  flag_in,
  output dbss_pkg::byte_t      byte_q,
  output logic                 flag_q,
  output dbss_pkg::cell_stat_t stat
);
  import dbss_pkg::*;

  byte_t           byte_r;
  logic            flag_r;
  logic            active;
  logic            first;
  logic [LEN_W-1:0] diff;
  logic [SEL_W-1:0] sel;
  byte_t           pat_byte;

  // This cell holds the text byte that lines up with pattern byte len-1-K.
  assign active   = LEN_W'(K) < eff_len;
  assign first    = (LEN_W'(K) + LEN_W'(1)) == eff_len;
  assign diff     = eff_len - LEN_W'(1) - LEN_W'(K);
  assign sel      = diff[SEL_W-1:0];
  assign pat_byte = pattern[8*sel +: 8];

  assign stat.hit      = !active || (byte_in == pat_byte);
  assign stat.start_ok = first && flag_in;

  always_ff @(posedge clk) begin
    if (!rst_n || (ctrl.shift && ctrl.clear)) begin
      byte_r <= '0;
      flag_r <= 1'b0;
    end else if (ctrl.shift) begin
      byte_r <= byte_in;
      flag_r <= flag_in;
    end
  end

  assign byte_q = byte_r;
  assign flag_q = flag_r;

endmodule
`default_nettype wire

### sv/double_byte_aware_substring_search.sv
// Double-byte aware substring search: top level with the cell chain and result register.
//
// Text bytes arrive on in_chan, one transfer per byte, with last_byte marking the
// final byte of a text. The pattern (1 to 8 bytes, first byte lowest) and its
// length are written through the cfg_ port by the user, only while the block is
// idle; the block does not enforce it. A match may only start on a character
// boundary: a start byte with bit 7 set is a double-byte lead, so the byte after
// it cannot start a match. Exactly one result per text leaves on out_chan: found
// with the 1-based start position when the first match completes, or found 0 on
// the last byte. The position saturates at 2^POSITION_BITS-1.
// One byte is taken every cycle while in_chan is not stalled; the window compare
// across the row of cells is combinational, and a result appears on out_chan in
// the cycle after the transfer of the byte that caused it.
// The output register holds a result until out_chan takes it; while it is full and
// out_chan is not ready, in_chan is stalled, whether or not the next byte would
// produce a result.
// Reset clears the window, the byte count and the result valid flag; the pattern
// resets to length 1 with all bytes zero. After the last byte of a text the
// window state returns to its reset value, the pattern registers are kept.
`default_nettype none
module double_byte_aware_substring_search #(
  parameter int MAX_PATTERN   = 8,
  parameter int POSITION_BITS = 16
) (
  input  wire                              clk,
  input  wire                              rst_n,
  dbss_in_if.sink                          in_chan,
  dbss_out_if.source                       out_chan,
  input  wire                              cfg_we,
  input  wire [dbss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [dbss_pkg::CFG_W-1:0]        cfg_wdata
);
  import dbss_pkg::*;

  localparam int CNT_W = POSITION_BITS + 1;
  localparam logic [CNT_W-1:0] POS_MAX   = {1'b0, {POSITION_BITS{1'b1}}};
  localparam logic [CNT_W-1:0] COUNT_CAP = POS_MAX + CNT_W'(MAX_PATTERN);

  pattern_t                 pattern_r;
  len_t                     len_r;
  len_t                     eff_len;
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  logic [CNT_W-1:0]         pos_raw;
  logic [POSITION_BITS-1:0] pos_sat;
  logic                     reported_r;
  logic                     nsa_r;
  logic                     nsa_nxt;
  logic                     accept;
  logic                     match_now;
  logic                     emit;
  logic                     all_hit;
  logic                     start_ok;
  logic                     out_valid_r;
  logic                     found_r;
  logic [POSITION_BITS-1:0] pos_r;
  cell_ctrl_t               ctrl;
  byte_t                    byte_in [MAX_PATTERN];
  byte_t                    byte_q  [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]   flag_in;
  logic [MAX_PATTERN-1:0]   flag_q;
  cell_stat_t               stat    [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]   hit_vec;
  logic [MAX_PATTERN-1:0]   start_vec;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      len_r     <= len_t'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_BYTES:  pattern_r <= cfg_wdata;
        REG_PATTERN_LENGTH: len_r     <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (len_r == '0) begin
      eff_len = len_t'(1);
    end else if (len_r > len_t'(MAX_PATTERN)) begin
      eff_len = len_t'(MAX_PATTERN);
    end else begin
      eff_len = len_r;
    end
  end

  // The result register must be free, or emptying this cycle, before a byte is taken.
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  assign ctrl.shift = accept;
  assign ctrl.clear = in_chan.last_byte;

  genvar k;
  generate
    for (k = 0; k < MAX_PATTERN; k++) begin : g_cell
      if (k == 0) begin : g_head
        assign byte_in[k] = in_chan.text_byte;
        assign flag_in[k] = nsa_r;
      end else begin : g_body
        assign byte_in[k] = byte_q[k-1];
        assign flag_in[k] = flag_q[k-1];
      end

      dbss_cell #(
        .K (k)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .pattern (pattern_r),
        .eff_len (eff_len),
        .byte_in (byte_in[k]),
        .flag_in (flag_in[k]),
        .byte_q  (byte_q[k]),
        .flag_q  (flag_q[k]),
        .stat    (stat[k])
      );

      assign hit_vec[k]   = stat[k].hit;
      assign start_vec[k] = stat[k].start_ok;
    end
  endgenerate

  assign all_hit  = &hit_vec;
  assign start_ok = |start_vec;

  assign count_nxt = (count_r < COUNT_CAP) ? count_r + CNT_W'(1) : count_r;
  assign nsa_nxt   = !(nsa_r && in_chan.text_byte[7]);

  // The start flag is only set for bytes of this text, so it also covers short texts.
  assign match_now = !reported_r && start_ok && all_hit;
  assign emit      = accept && (match_now || (in_chan.last_byte && !reported_r));

  assign pos_raw = count_nxt - CNT_W'(eff_len) + CNT_W'(1);
  assign pos_sat = (pos_raw > POS_MAX) ? POS_MAX[POSITION_BITS-1:0]
                                       : pos_raw[POSITION_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      reported_r <= 1'b0;
      nsa_r      <= 1'b1;
    end else if (accept) begin
      if (in_chan.last_byte) begin
        count_r    <= '0;
        reported_r <= 1'b0;
        nsa_r      <= 1'b1;
      end else begin
        count_r    <= count_nxt;
        reported_r <= reported_r || match_now;
        nsa_r      <= nsa_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      found_r <= match_now;
      pos_r   <= match_now ? pos_sat : '0;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.found          = found_r;
  assign out_chan.start_position = pos_r;

  a_found_pos : assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.found |-> out_chan.start_position != '0)
    else $error("found result carries a zero start position");

  a_miss_pos : assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.found |-> out_chan.start_position == '0)
    else $error("miss result carries a non-zero start position");

  a_text_end : assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_chan.last_byte |=> count_r == '0 && !reported_r && nsa_r)
    else $error("text state not cleared after the last byte");

  a_one_result : assert property (@(posedge clk) disable iff (!rst_n)
    accept && reported_r && !in_chan.last_byte |=> !$rose(out_valid_r))
    else $error("second result for a text that already reported a match");

endmodule
`default_nettype wire
